### rtl/qmm_pkg.sv
// Shared types, constants and register map of the quad motor mixer.
// Used by the channel interfaces and by every qmm module; no dependencies.
package qmm_pkg;

   // Field widths
   localparam int PULSE_W = 12;
   localparam int CORR_W  = 11;
   localparam int FUNC_W  = 2;
   // Signed width of the X-frame sums: 12-bit throttle plus three 11-bit terms
   localparam int SUM_W   = 14;

   // Operation codes; the unused code acts as a stop
   localparam logic [FUNC_W-1:0] FUNC_MIX    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DIRECT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_STOP   = 2'd2;

   // Throttle shaping: floor at BASE_PULSE, excess scaled by 85/100.
   // floor(e*85/100) == (e*SCALE_MUL) >> SCALE_SHIFT for every e below 8192.
   localparam logic [PULSE_W-1:0] BASE_PULSE  = 12'd1000;
   localparam int                 SCALE_SHIFT = 16;
   localparam logic [15:0]        SCALE_MUL   = 16'd55706;
   localparam int                 SCALE_PW    = PULSE_W + 16;

   // Duty conversion defaults
   localparam int DUTY_FULL_DEF = 16383;
   localparam int PERIOD_US_DEF = 20000;

   // Register map (byte address 4*index)
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;
   localparam logic [1:0] REG_MAX_PULSE  = 2'd0;
   localparam logic [1:0] REG_IDLE_PULSE = 2'd1;
   localparam logic [1:0] REG_OFF_PULSE  = 2'd2;

   localparam logic [PULSE_W-1:0] MAX_PULSE_RST  = 12'd1800;
   localparam logic [PULSE_W-1:0] IDLE_PULSE_RST = 12'd1080;
   localparam logic [PULSE_W-1:0] OFF_PULSE_RST  = 12'd1000;

   // Stages from input to result register
   localparam int PIPE_DEPTH = 8;

   typedef logic [PULSE_W-1:0]       pulse_type;
   typedef pulse_type [3:0]          quad_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef sum_type [3:0]            sum_quad_type;

   typedef struct packed {
      pulse_type max_pulse;
      pulse_type idle_pulse;
      pulse_type off_pulse;
   } cfg_type;

   typedef struct packed {
      logic signed [CORR_W-1:0] pitch;
      logic signed [CORR_W-1:0] roll;
      logic signed [CORR_W-1:0] yaw;
   } corr_type;

   // Handoff from the sum stage to the desaturation stages
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      quad_type          direct;
      sum_quad_type      sum;
   } sum_stage_type;

endpackage

### rtl/qmm_if.sv
// Valid/ready channel interfaces for mixer requests and results.
// Depends on qmm_pkg for field widths.
interface qmm_req_if;
   logic                                valid;
   logic                                ready;
   logic [qmm_pkg::FUNC_W-1:0]          func;
   logic [qmm_pkg::PULSE_W-1:0]         throttle_in;
   logic signed [qmm_pkg::CORR_W-1:0]   pitch_corr;
   logic signed [qmm_pkg::CORR_W-1:0]   roll_corr;
   logic signed [qmm_pkg::CORR_W-1:0]   yaw_corr;
   logic [qmm_pkg::PULSE_W-1:0]         direct_a;
   logic [qmm_pkg::PULSE_W-1:0]         direct_b;
   logic [qmm_pkg::PULSE_W-1:0]         direct_c;
   logic [qmm_pkg::PULSE_W-1:0]         direct_d;

   modport source (output valid, func, throttle_in, pitch_corr, roll_corr, yaw_corr,
                   direct_a, direct_b, direct_c, direct_d, input ready);
   modport sink   (input valid, func, throttle_in, pitch_corr, roll_corr, yaw_corr,
                   direct_a, direct_b, direct_c, direct_d, output ready);
endinterface

interface qmm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [qmm_pkg::PULSE_W-1:0] pulse_a;
   logic [qmm_pkg::PULSE_W-1:0] pulse_b;
   logic [qmm_pkg::PULSE_W-1:0] pulse_c;
   logic [qmm_pkg::PULSE_W-1:0] pulse_d;
   logic [qmm_pkg::PULSE_W-1:0] duty_a;
   logic [qmm_pkg::PULSE_W-1:0] duty_b;
   logic [qmm_pkg::PULSE_W-1:0] duty_c;
   logic [qmm_pkg::PULSE_W-1:0] duty_d;

   modport source (output valid, pulse_a, pulse_b, pulse_c, pulse_d,
                   duty_a, duty_b, duty_c, duty_d, input ready);
   modport sink   (input valid, pulse_a, pulse_b, pulse_c, pulse_d,
                   duty_a, duty_b, duty_c, duty_d, output ready);
endinterface

### rtl/qmm_mix.sv
// Front of the mixer pipeline: throttle scaling, capping and the four X-frame sums.
// Depends on qmm_pkg and qmm_req_if; feeds qmm_desat.
module qmm_mix (
   input  logic                   clock,
   input  logic                   reset,
   input  qmm_pkg::cfg_type       cfg,
   qmm_req_if.sink                req_if,
   output logic                   sum_valid,
   input  logic                   sum_ready,
   output qmm_pkg::sum_stage_type sum_stage
);

   localparam int SW = qmm_pkg::SUM_W;
   localparam int PW = qmm_pkg::SCALE_PW;

   logic en1, en2, en3;

   // stage 1: floored throttle excess times 0.85 in fixed point
   logic                               v1_ff;
   logic [qmm_pkg::FUNC_W-1:0]         func1_ff;
   logic [PW-1:0]                      prod1_ff, prod1_in;
   qmm_pkg::corr_type                  corr1_ff;
   qmm_pkg::quad_type                  direct1_ff;
   logic [qmm_pkg::PULSE_W-1:0]        excess;

   // stage 2: capped throttle
   logic                               v2_ff;
   logic [qmm_pkg::FUNC_W-1:0]         func2_ff;
   qmm_pkg::pulse_type                 thr2_ff, thr2_in, thr_raw;
   qmm_pkg::corr_type                  corr2_ff;
   qmm_pkg::quad_type                  direct2_ff;

   // stage 3: sums
   logic                               v3_ff;
   qmm_pkg::sum_stage_type             sum3_ff, sum3_in;
   qmm_pkg::sum_type                   t, pc, rc, yc;

   // ready chain: a stage loads when empty or when its successor moves
   assign en3          = !v3_ff || sum_ready;
   assign en2          = !v2_ff || en3;
   assign en1          = !v1_ff || en2;
   assign req_if.ready = en1;

   always_comb begin
      if (req_if.throttle_in < qmm_pkg::BASE_PULSE) begin
         excess = '0;
      end else begin
         excess = req_if.throttle_in - qmm_pkg::BASE_PULSE;
      end
      prod1_in = PW'(excess) * PW'(qmm_pkg::SCALE_MUL);
   end

   always_comb begin
      thr_raw = qmm_pkg::BASE_PULSE
              + prod1_ff[qmm_pkg::SCALE_SHIFT +: qmm_pkg::PULSE_W];
      if (thr_raw > cfg.max_pulse) begin
         thr2_in = cfg.max_pulse;
      end else begin
         thr2_in = thr_raw;
      end
   end

   // X frame: a = T-P+R-Y, b = T+P+R+Y, c = T+P-R-Y, d = T-P-R+Y
   always_comb begin
      t  = $signed({{(SW - qmm_pkg::PULSE_W){1'b0}}, thr2_ff});
      pc = SW'(corr2_ff.pitch);
      rc = SW'(corr2_ff.roll);
      yc = SW'(corr2_ff.yaw);
      sum3_in.func   = func2_ff;
      sum3_in.direct = direct2_ff;
      sum3_in.sum[0] = t - pc + rc - yc;
      sum3_in.sum[1] = t + pc + rc + yc;
      sum3_in.sum[2] = t + pc - rc - yc;
      sum3_in.sum[3] = t - pc - rc + yc;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_if.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en1) begin
         func1_ff      <= req_if.func;
         prod1_ff      <= prod1_in;
         corr1_ff      <= '{pitch: req_if.pitch_corr, roll: req_if.roll_corr,
                            yaw: req_if.yaw_corr};
         direct1_ff[0] <= req_if.direct_a;
         direct1_ff[1] <= req_if.direct_b;
         direct1_ff[2] <= req_if.direct_c;
         direct1_ff[3] <= req_if.direct_d;
      end
      if (en2) begin
         func2_ff   <= func1_ff;
         thr2_ff    <= thr2_in;
         corr2_ff   <= corr1_ff;
         direct2_ff <= direct1_ff;
      end
      if (en3) begin
         sum3_ff <= sum3_in;
      end
   end

   assign sum_valid = v3_ff;
   assign sum_stage = sum3_ff;

endmodule

### rtl/qmm_desat.sv
// Desaturation and clamping: largest sum, excess removal, idle/max clamp, op select.
// Depends on qmm_pkg; sits between qmm_mix and qmm_duty.
module qmm_desat (
   input  logic                   clock,
   input  logic                   reset,
   input  qmm_pkg::cfg_type       cfg,
   input  logic                   sum_valid,
   output logic                   sum_ready,
   input  qmm_pkg::sum_stage_type sum_stage,
   output logic                   pulse_valid,
   input  logic                   pulse_ready,
   output qmm_pkg::quad_type      pulse
);

   localparam int SW = qmm_pkg::SUM_W;

   logic en4, en5, en6;

   // stage 4: sums and their maximum
   logic                   v4_ff;
   qmm_pkg::sum_stage_type s4_ff;
   qmm_pkg::sum_type       top4_ff, top4_in, m01, m23;

   // stage 5: sums after excess removal
   logic                   v5_ff;
   qmm_pkg::sum_stage_type s5_ff, s5_in;
   qmm_pkg::sum_type       max_s, idle_s;

   // stage 6: final pulses
   logic                   v6_ff;
   qmm_pkg::quad_type      p6_ff, p6_in;

   assign en6       = !v6_ff || pulse_ready;
   assign en5       = !v5_ff || en6;
   assign en4       = !v4_ff || en5;
   assign sum_ready = en4;

   assign max_s  = $signed({{(SW - qmm_pkg::PULSE_W){1'b0}}, cfg.max_pulse});
   assign idle_s = $signed({{(SW - qmm_pkg::PULSE_W){1'b0}}, cfg.idle_pulse});

   // two-level max tree
   always_comb begin
      m01     = (sum_stage.sum[1] > sum_stage.sum[0]) ? sum_stage.sum[1] : sum_stage.sum[0];
      m23     = (sum_stage.sum[3] > sum_stage.sum[2]) ? sum_stage.sum[3] : sum_stage.sum[2];
      top4_in = (m23 > m01) ? m23 : m01;
   end

   // shift all four down by the excess of the largest over max
   always_comb begin
      s5_in = s4_ff;
      if (top4_ff > max_s) begin
         for (int k = 0; k < 4; k++) begin
            s5_in.sum[k] = s4_ff.sum[k] - top4_ff + max_s;
         end
      end
   end

   // clamp (lower bound tested first) and op select
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         case (s5_ff.func)
            qmm_pkg::FUNC_MIX: begin
               if (s5_ff.sum[k] < idle_s) begin
                  p6_in[k] = cfg.idle_pulse;
               end else if (s5_ff.sum[k] > max_s) begin
                  p6_in[k] = cfg.max_pulse;
               end else begin
                  p6_in[k] = s5_ff.sum[k][qmm_pkg::PULSE_W-1:0];
               end
            end
            qmm_pkg::FUNC_DIRECT: begin
               p6_in[k] = s5_ff.direct[k];
            end
            default: begin
               p6_in[k] = cfg.off_pulse;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en4) v4_ff <= sum_valid;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_ff   <= sum_stage;
         top4_ff <= top4_in;
      end
      if (en5) begin
         s5_ff <= s5_in;
      end
      if (en6) begin
         p6_ff <= p6_in;
      end
   end

   assign pulse_valid = v6_ff;
   assign pulse       = p6_ff;

endmodule

### rtl/qmm_duty.sv
// Duty conversion pulse*DUTY_FULL/PERIOD_US (floored) and the result register.
// Depends on qmm_pkg and qmm_rsp_if; fed by qmm_desat.
module qmm_duty #(
   parameter int DUTY_FULL = qmm_pkg::DUTY_FULL_DEF,
   parameter int PERIOD_US = qmm_pkg::PERIOD_US_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pulse_valid,
   output logic              pulse_ready,
   input  qmm_pkg::quad_type pulse,
   qmm_rsp_if.source         rsp_if
);

   localparam int PW = qmm_pkg::PULSE_W;
   // Reciprocal multiply, exact for any 12-bit pulse
   localparam int          DUTY_SHIFT = PW + $clog2(PERIOD_US);
   localparam logic [63:0] DUTY_MUL   = ((64'(DUTY_FULL) << DUTY_SHIFT)
                                         + 64'(PERIOD_US) - 64'd1) / 64'(PERIOD_US);
   localparam int          MUL_W      = $clog2(DUTY_MUL + 64'd1);
   localparam int          PROD_W     = (PW + MUL_W > DUTY_SHIFT + PW) ?
                                        PW + MUL_W : DUTY_SHIFT + PW;

   logic en7, en8;

   // stage 7: products
   logic                    v7_ff;
   qmm_pkg::quad_type       p7_ff;
   logic [3:0][PROD_W-1:0]  prod7_ff, prod7_in;

   // stage 8: result register
   logic                    v8_ff;
   qmm_pkg::quad_type       p8_ff, d8_ff, d8_in;

   assign en8         = !v8_ff || rsp_if.ready;
   assign en7         = !v7_ff || en8;
   assign pulse_ready = en7;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         prod7_in[k] = PROD_W'(pulse[k]) * PROD_W'(DUTY_MUL);
         d8_in[k]    = prod7_ff[k][DUTY_SHIFT +: PW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else begin
         if (en7) v7_ff <= pulse_valid;
         if (en8) v8_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en7) begin
         p7_ff    <= pulse;
         prod7_ff <= prod7_in;
      end
      if (en8) begin
         p8_ff <= p7_ff;
         d8_ff <= d8_in;
      end
   end

   assign rsp_if.valid   = v8_ff;
   assign rsp_if.pulse_a = p8_ff[0];
   assign rsp_if.pulse_b = p8_ff[1];
   assign rsp_if.pulse_c = p8_ff[2];
   assign rsp_if.pulse_d = p8_ff[3];
   assign rsp_if.duty_a  = d8_ff[0];
   assign rsp_if.duty_b  = d8_ff[1];
   assign rsp_if.duty_c  = d8_ff[2];
   assign rsp_if.duty_d  = d8_ff[3];

endmodule

### rtl/quad_motor_mixer.sv
// Quadcopter X-frame motor mixer, pipeline top level with register port.
// Depends on qmm_pkg, qmm_if, qmm_mix, qmm_desat and qmm_duty.
//
// Each request (mix, direct write or stop) yields one result of four motor
// pulses and four duty counts. The block is an eight-stage pipeline that takes
// one request per clock unless stalls from the result side have filled it.
// Stalls from the result side back up stage by stage, so empty stages still
// fill while the output waits. The stages are the throttle-scaling multiply,
// the throttle cap, the X-frame sums, the max tree, the excess removal, the
// clamp, the duty multiply and the result register, one stage each.
// Registers: max_pulse at 0x0, idle_pulse at 0x4, off_pulse at 0x8, 12 bits
// each; write them only while no request is in flight.
module quad_motor_mixer #(
   parameter int DUTY_FULL = qmm_pkg::DUTY_FULL_DEF,
   parameter int PERIOD_US = qmm_pkg::PERIOD_US_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   qmm_req_if.sink                    req_if,
   qmm_rsp_if.source                  rsp_if,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [qmm_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [qmm_pkg::DATA_W-1:0] csr_pwdata,
   output logic [qmm_pkg::DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   qmm_pkg::cfg_type       cfg_ff;
   logic                   csr_wr;
   logic [1:0]             csr_idx;

   logic                   sum_valid, sum_ready;
   qmm_pkg::sum_stage_type sum_stage;
   logic                   pulse_valid, pulse_ready;
   qmm_pkg::quad_type      pulse;

   // requests in flight, for checking only
   logic [3:0]             inflight_ff, inflight_in;
   logic                   req_acc, rsp_acc;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_pulse  <= qmm_pkg::MAX_PULSE_RST;
         cfg_ff.idle_pulse <= qmm_pkg::IDLE_PULSE_RST;
         cfg_ff.off_pulse  <= qmm_pkg::OFF_PULSE_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            qmm_pkg::REG_MAX_PULSE:  cfg_ff.max_pulse  <= csr_pwdata[qmm_pkg::PULSE_W-1:0];
            qmm_pkg::REG_IDLE_PULSE: cfg_ff.idle_pulse <= csr_pwdata[qmm_pkg::PULSE_W-1:0];
            qmm_pkg::REG_OFF_PULSE:  cfg_ff.off_pulse  <= csr_pwdata[qmm_pkg::PULSE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         qmm_pkg::REG_MAX_PULSE:  csr_prdata = qmm_pkg::DATA_W'(cfg_ff.max_pulse);
         qmm_pkg::REG_IDLE_PULSE: csr_prdata = qmm_pkg::DATA_W'(cfg_ff.idle_pulse);
         qmm_pkg::REG_OFF_PULSE:  csr_prdata = qmm_pkg::DATA_W'(cfg_ff.off_pulse);
         default:                 csr_prdata = '0;
      endcase
   end

   // pipeline
   qmm_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_if    (req_if),
      .sum_valid (sum_valid),
      .sum_ready (sum_ready),
      .sum_stage (sum_stage)
   );

   qmm_desat u_desat (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .sum_valid   (sum_valid),
      .sum_ready   (sum_ready),
      .sum_stage   (sum_stage),
      .pulse_valid (pulse_valid),
      .pulse_ready (pulse_ready),
      .pulse       (pulse)
   );

   qmm_duty #(
      .DUTY_FULL (DUTY_FULL),
      .PERIOD_US (PERIOD_US)
   ) u_duty (
      .clock       (clock),
      .reset       (reset),
      .pulse_valid (pulse_valid),
      .pulse_ready (pulse_ready),
      .pulse       (pulse),
      .rsp_if      (rsp_if)
   );

   // occupancy tracking
   assign req_acc     = req_if.valid && req_if.ready;
   assign rsp_acc     = rsp_if.valid && rsp_if.ready;
   assign inflight_in = inflight_ff + 4'(req_acc) - 4'(rsp_acc);

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // a free output must open the whole ready chain
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_if.ready |-> req_if.ready)
      else $error("request side stalled while result side is ready");

   // never more requests in flight than pipeline stages
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= 4'(qmm_pkg::PIPE_DEPTH))
      else $error("pipeline holds more requests than stages");

   // no result without an outstanding request
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (inflight_ff == 4'd0) |-> !rsp_if.valid)
      else $error("result presented with no request in flight");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("result valid right after reset");

endmodule
